>>> design/grs_pkg.sv
`timescale 1ns / 1ps

package grs_pkg;

  localparam int MAX_GROUP  = 64;
  localparam int DATA_WIDTH = 32;
  localparam int CNT_W      = $clog2(MAX_GROUP + 1);
  localparam int CFG_W      = 7;
  localparam int CMP_W      = (CFG_W > CNT_W) ? CFG_W : CNT_W;

  localparam logic [CFG_W-1:0] GROUP_SIZE_RESET = CFG_W'(2);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EMIT_REV,
    ST_ALIGN,
    ST_EMIT_FWD
  } state_e;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_PUSH,
    OP_POP,
    OP_UP
  } shift_op_e;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] value;
    logic                  run_last;
    logic                  sequence_end;
  } out_item_t;

endpackage

>>> design/grs_if.sv
`timescale 1ns / 1ps

interface grs_in_if import grs_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] value;
  logic                         final_element;

  modport source (output valid, output value, output final_element, input ready);
  modport sink (input valid, input value, input final_element, output ready);
endinterface

interface grs_out_if import grs_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] out_value;
  logic                         run_last;
  logic                         sequence_end;

  modport source (output valid, output out_value, output run_last, output sequence_end,
                  input ready);
  modport sink (input valid, input out_value, input run_last, input sequence_end,
                output ready);
endinterface

>>> design/grs_cell.sv
`timescale 1ns / 1ps

module grs_cell import grs_pkg::*; (
  input  logic                  clk_i,
  input  shift_op_e             op_i,
  input  logic [DATA_WIDTH-1:0] lower_i,
  input  logic [DATA_WIDTH-1:0] upper_i,
  output logic [DATA_WIDTH-1:0] value_o
);

  logic [DATA_WIDTH-1:0] value_q;
  logic [DATA_WIDTH-1:0] value_d;

  always_comb begin
    case (op_i)
      OP_PUSH: value_d = lower_i;
      OP_UP:   value_d = lower_i;
      OP_POP:  value_d = upper_i;
      OP_HOLD: value_d = value_q;
      default: value_d = value_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

>>> design/grs_ctrl.sv
`timescale 1ns / 1ps

module grs_ctrl import grs_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_W-1:0]      cfg_wdata_i,
  input  logic                  in_valid_i,
  input  logic                  in_final_i,
  output logic                  in_ready_o,
  input  logic [DATA_WIDTH-1:0] head_i,
  input  logic [DATA_WIDTH-1:0] tail_i,
  output shift_op_e             op_o,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output out_item_t             out_item_o
);

  state_e            state_q, state_d;
  logic [CFG_W-1:0]  group_size_q;
  logic [CNT_W-1:0]  fill_q;
  logic [CNT_W-1:0]  align_q;
  logic              final_q;
  logic              out_valid_q;
  out_item_t         out_item_q;
  out_item_t         item_d;

  logic              accept;
  logic              move;
  logic              n_ge_size;
  logic [CNT_W-1:0]  n;
  logic [CMP_W-1:0]  size_eff;
  logic [CMP_W-1:0]  size_ext;

  assign n        = fill_q + CNT_W'(1);
  assign size_ext = CMP_W'(group_size_q);

  // group size zero acts as one, large sizes saturate
  always_comb begin
    if (group_size_q == '0) begin
      size_eff = CMP_W'(1);
    end else if (size_ext > CMP_W'(MAX_GROUP)) begin
      size_eff = CMP_W'(MAX_GROUP);
    end else begin
      size_eff = size_ext;
    end
  end

  assign n_ge_size = CMP_W'(n) >= size_eff;

  // outputs of the state machine
  always_comb begin
    in_ready_o = (state_q == ST_IDLE);
    accept     = in_valid_i && in_ready_o;
    move       = ((state_q == ST_EMIT_REV) || (state_q == ST_EMIT_FWD)) &&
                 (!out_valid_q || out_ready_i);
    case (state_q)
      ST_IDLE:     op_o = accept ? OP_PUSH : OP_HOLD;
      ST_EMIT_REV: op_o = move ? OP_POP : OP_HOLD;
      ST_ALIGN:    op_o = OP_UP;
      ST_EMIT_FWD: op_o = move ? OP_UP : OP_HOLD;
      default:     op_o = OP_HOLD;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && n_ge_size) begin
          state_d = ST_EMIT_REV;
        end else if (accept && in_final_i) begin
          state_d = ST_ALIGN;
        end
      end
      ST_EMIT_REV, ST_EMIT_FWD: begin
        if (move && (fill_q == CNT_W'(1))) begin
          state_d = ST_IDLE;
        end
      end
      ST_ALIGN: begin
        if (align_q == CNT_W'(1)) begin
          state_d = ST_EMIT_FWD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    item_d.value        = (state_q == ST_EMIT_REV) ? head_i : tail_i;
    item_d.run_last     = (fill_q == CNT_W'(1));
    item_d.sequence_end = (fill_q == CNT_W'(1)) && final_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      group_size_q <= GROUP_SIZE_RESET;
      fill_q       <= '0;
      align_q      <= '0;
      final_q      <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        group_size_q <= cfg_wdata_i;
      end
      if (accept) begin
        fill_q  <= n;
        align_q <= CNT_W'(MAX_GROUP) - n;
        final_q <= in_final_i;
      end else if (move) begin
        fill_q <= fill_q - CNT_W'(1);
      end else if (state_q == ST_ALIGN) begin
        align_q <= align_q - CNT_W'(1);
      end
      if (move) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (move) begin
      out_item_q <= item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

>>> design/group_reverse_stream.sv
`timescale 1ns / 1ps
// channel  | dir | handshake   | payload
// in_i     | in  | valid/ready | value, final_element
// out_o    | out | valid/ready | out_value, run_last, sequence_end
// cfg      | in  | cfg_we_i    | cfg_wdata_i (group size)
//
// elements that do not close a group are taken one per cycle into the cell chain
// a full group of n leaves newest first, one cell shift per request
// a short final group first shifts up to the chain end, then leaves oldest first
// output stalls hold the chain; no request is taken while a group drains
// reset clears the fill count and sets the group size to 2

module group_reverse_stream import grs_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  grs_in_if.sink           in_i,
  grs_out_if.source        out_o
);

  shift_op_e             op;
  out_item_t             out_item;
  logic [DATA_WIDTH-1:0] chain [MAX_GROUP];

  grs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_i.valid),
    .in_final_i  (in_i.final_element),
    .in_ready_o  (in_i.ready),
    .head_i      (chain[0]),
    .tail_i      (chain[MAX_GROUP-1]),
    .op_o        (op),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .out_item_o  (out_item)
  );

  for (genvar k = 0; k < MAX_GROUP; k++) begin : g_cell
    logic [DATA_WIDTH-1:0] lower;
    logic [DATA_WIDTH-1:0] upper;

    if (k == 0) begin : g_first
      assign lower = in_i.value;
    end else begin : g_mid
      assign lower = chain[k-1];
    end

    if (k == MAX_GROUP - 1) begin : g_last
      assign upper = chain[k];
    end else begin : g_inner
      assign upper = chain[k+1];
    end

    grs_cell u_cell (
      .clk_i   (clk_i),
      .op_i    (op),
      .lower_i (lower),
      .upper_i (upper),
      .value_o (chain[k])
    );
  end

  assign out_o.out_value    = out_item.value;
  assign out_o.run_last     = out_item.run_last;
  assign out_o.sequence_end = out_item.sequence_end;

endmodule

>>> design/grs_checker.sv
`timescale 1ns / 1ps

module grs_checker import grs_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_i,
  input logic                  in_final_i,
  input logic                  out_valid_i,
  input logic                  out_ready_i,
  input logic [DATA_WIDTH-1:0] out_value_i,
  input logic                  run_last_i,
  input logic                  sequence_end_i
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && sequence_end_i |-> run_last_i)
    else $error("sequence end without run last");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_final_i |=> !in_ready_i)
    else $error("final request did not start a drain");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output request dropped");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_value_i))
    else $error("stalled output changed");

endmodule

bind group_reverse_stream grs_checker u_grs_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .in_final_i     (in_i.final_element),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_value_i    (out_o.out_value),
  .run_last_i     (out_o.run_last),
  .sequence_end_i (out_o.sequence_end)
);

>>> tb/group_reverse_stream_test.sv
`timescale 1ns / 1ps

module group_reverse_stream_test;
  import grs_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES   = 200;
  localparam int unsigned STALL_LIMIT   = 4000;
  localparam int unsigned DRAIN_CYCLES  = 2 * MAX_GROUP + 16;
  localparam int unsigned RANDOM_ITEMS  = 86;
  localparam int unsigned N_ROWS        = 20;

  typedef enum logic {
    ROW_ITEM,
    ROW_CFG
  } row_op_e;

  typedef enum logic [1:0] {
    SPOT_MODEL,
    SPOT_NONE,
    SPOT_ONE
  } spot_e;

  typedef struct packed {
    row_op_e               op;
    logic [DATA_WIDTH-1:0] data;
    logic                  fin;
    spot_e                 spot;
    out_item_t             want;
  } script_row_t;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CFG_W-1:0] cfg_wdata_i;

  grs_in_if  in_ch ();
  grs_out_if out_ch ();

  group_reverse_stream uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  // directed requests, group size starts at 2 after reset
  script_row_t script [N_ROWS] = '{
    '{ROW_ITEM, 32'h8000_0000, 1'b0, SPOT_NONE,  '0},
    '{ROW_ITEM, 32'h7FFF_FFFF, 1'b0, SPOT_MODEL, '0},
    '{ROW_ITEM, 32'hFFFF_FFFF, 1'b1, SPOT_ONE,   out_item_t'{32'hFFFF_FFFF, 1'b1, 1'b1}},
    '{ROW_CFG,  32'd0,         1'b0, SPOT_MODEL, '0},
    '{ROW_ITEM, 32'h0000_0000, 1'b0, SPOT_ONE,   out_item_t'{32'h0000_0000, 1'b1, 1'b0}},
    '{ROW_ITEM, 32'hAAAA_AAAA, 1'b1, SPOT_ONE,   out_item_t'{32'hAAAA_AAAA, 1'b1, 1'b1}},
    '{ROW_CFG,  32'd3,         1'b0, SPOT_MODEL, '0},
    '{ROW_ITEM, 32'h5555_5555, 1'b0, SPOT_NONE,  '0},
    '{ROW_ITEM, 32'h0000_0001, 1'b0, SPOT_NONE,  '0},
    '{ROW_ITEM, 32'h8000_0001, 1'b1, SPOT_MODEL, '0},
    '{ROW_CFG,  32'd4,         1'b0, SPOT_MODEL, '0},
    '{ROW_ITEM, 32'h1234_5678, 1'b0, SPOT_NONE,  '0},
    '{ROW_ITEM, 32'hFEDC_BA98, 1'b0, SPOT_NONE,  '0},
    '{ROW_CFG,  32'd2,         1'b0, SPOT_MODEL, '0},
    '{ROW_ITEM, 32'h0000_FFFF, 1'b0, SPOT_MODEL, '0},
    '{ROW_CFG,  32'd5,         1'b0, SPOT_MODEL, '0},
    '{ROW_ITEM, 32'hFFFF_0000, 1'b0, SPOT_NONE,  '0},
    '{ROW_ITEM, 32'h7FFF_FFFE, 1'b1, SPOT_MODEL, '0},
    '{ROW_CFG,  32'd127,       1'b0, SPOT_MODEL, '0},
    '{ROW_ITEM, 32'h0000_0002, 1'b1, SPOT_MODEL, '0}
  };

  logic [CFG_W-1:0]      size_reg;
  logic [DATA_WIDTH-1:0] held_buf [MAX_GROUP];
  int unsigned           held;
  out_item_t             reversed_q [$];

  spot_e       drv_spot;
  out_item_t   drv_want;
  int unsigned holds_asked;
  int unsigned holds_done;
  int unsigned quiet_cycles;
  int unsigned mismatch_count;
  int unsigned queued_before;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [DATA_WIDTH-1:0] rand_value();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic int unsigned eff_size(logic [CFG_W-1:0] s);
    if (s == 0) return 1;
    if (s > MAX_GROUP) return MAX_GROUP;
    return s;
  endfunction

  task automatic collect_and_reverse(logic [DATA_WIDTH-1:0] v, logic fin);
    int unsigned n;
    int unsigned i;
    if (held < MAX_GROUP) begin
      held_buf[held] = v;
      held++;
    end
    n = held;
    if (n >= eff_size(size_reg)) begin
      for (i = 0; i < n; i++) begin
        reversed_q.push_back(out_item_t'{held_buf[n-1-i], i + 1 == n, (i + 1 == n) && fin});
      end
      held = 0;
    end else if (fin) begin
      for (i = 0; i < n; i++) begin
        reversed_q.push_back(out_item_t'{held_buf[i], i + 1 == n, i + 1 == n});
      end
      held = 0;
    end
  endtask

  task automatic log_miss(string msg);
    if (mismatch_count < 10) $display("%s", msg);
    mismatch_count++;
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      size_reg     = GROUP_SIZE_RESET;
      held         = 0;
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (cfg_we_i) size_reg = cfg_wdata_i;
      if (in_ch.valid && in_ch.ready) begin
        quiet_cycles  = 0;
        queued_before = reversed_q.size();
        collect_and_reverse(in_ch.value, in_ch.final_element);
        if (drv_spot != SPOT_MODEL) begin
          while (reversed_q.size() > queued_before) void'(reversed_q.pop_back());
          if (drv_spot == SPOT_ONE) reversed_q.push_back(drv_want);
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        quiet_cycles = 0;
        if (reversed_q.size() == 0) begin
          log_miss($sformatf("unexpected result: value %h last %b end %b",
                             out_ch.out_value, out_ch.run_last, out_ch.sequence_end));
        end else if (out_ch.out_value !== reversed_q[0].value ||
                     out_ch.run_last !== reversed_q[0].run_last ||
                     out_ch.sequence_end !== reversed_q[0].sequence_end) begin
          log_miss($sformatf({"mismatch: expected value %h last %b end %b, ",
                              "got value %h last %b end %b"},
                             reversed_q[0].value, reversed_q[0].run_last,
                             reversed_q[0].sequence_end, out_ch.out_value,
                             out_ch.run_last, out_ch.sequence_end));
          void'(reversed_q.pop_front());
        end else begin
          void'(reversed_q.pop_front());
        end
      end
    end
  end

  initial begin
    wait (quiet_cycles >= STALL_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  // output side: random stalls plus one long hold-off on request
  initial begin
    int unsigned gap;
    int unsigned run;
    out_ch.ready <= 1'b0;
    holds_done = 0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (holds_asked != holds_done) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        holds_done++;
      end else begin
        out_ch.ready <= 1'b1;
        run = $urandom_range(1, 30);
        do begin
          @(posedge clk_i);
          run--;
        end while (run > 0 && holds_asked == holds_done);
        gap = pick_gap();
        if (gap > 0 && holds_asked == holds_done) begin
          out_ch.ready <= 1'b0;
          do begin
            @(posedge clk_i);
            gap--;
          end while (gap > 0 && holds_asked == holds_done);
        end
      end
    end
  end

  task automatic send_item(logic [DATA_WIDTH-1:0] v, logic fin, spot_e spot, out_item_t want);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid         <= 1'b1;
    in_ch.value         <= v;
    in_ch.final_element <= fin;
    drv_spot            <= spot;
    drv_want            <= want;
    @(posedge clk_i);
    while (!(in_ch.valid && in_ch.ready)) @(posedge clk_i);
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (reversed_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_group_size(logic [CFG_W-1:0] s);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= s;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    int unsigned      row;
    int unsigned      phase;
    int unsigned      sent;
    int unsigned      len;
    int unsigned      k;
    logic             end_fin;
    logic [CFG_W-1:0] size;

    rst_ni              <= 1'b0;
    cfg_we_i            <= 1'b0;
    cfg_wdata_i         <= '0;
    in_ch.valid         <= 1'b0;
    in_ch.value         <= '0;
    in_ch.final_element <= 1'b0;
    drv_spot            <= SPOT_MODEL;
    drv_want            <= '0;
    holds_asked         = 0;
    mismatch_count      = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (row = 0; row < N_ROWS; row++) begin
      if (script[row].op == ROW_CFG) begin
        write_group_size(script[row].data[CFG_W-1:0]);
      end else begin
        send_item(script[row].data, script[row].fin, script[row].spot, script[row].want);
      end
    end

    phase = 0;
    sent  = 0;
    while (sent < RANDOM_ITEMS) begin
      end_fin = ($urandom_range(0, 3) != 0);
      case (phase)
        0: begin
          // saturated size, one full group of the largest size
          size = 7'd127;
          len  = MAX_GROUP;
        end
        1: begin
          size    = 7'd64;
          len     = $urandom_range(3, 20);
          end_fin = 1'b1;
        end
        2: begin
          size = 7'd3;
          len  = 20;
        end
        default: begin
          case ($urandom_range(0, 15))
            0: size = 7'd0;
            1: size = CFG_W'($urandom_range(65, 127));
            2: size = CFG_W'($urandom_range(9, 64));
            default: size = CFG_W'($urandom_range(1, 8));
          endcase
          if (eff_size(size) > 8) len = $urandom_range(1, 6);
          else len = $urandom_range(1, 3 * eff_size(size) + 2);
        end
      endcase
      write_group_size(size);
      if (phase == 2) holds_asked <= holds_asked + 1;
      for (k = 0; k < len; k++) begin
        send_item(rand_value(), (k + 1 == len) && end_fin, SPOT_MODEL, '0);
      end
      sent += len;
      phase++;
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0 && reversed_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
